// ===== hw/rtl/fat12cw_pkg.sv =====
// Shared types, codes and constants of the FAT12 cluster chain walker.
`default_nettype none

package fat12cw_pkg;

  localparam int FAT_BYTES_DEF = 8192;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_ADV   = 2'd2;

  localparam logic [1:0] CFG_DATA_OFFSET   = 2'd0;
  localparam logic [1:0] CFG_CLUSTER_BYTES = 2'd1;
  localparam logic [1:0] CFG_CLUSTER_LIMIT = 2'd2;
  localparam logic [1:0] CFG_IMAGE_BYTES   = 2'd3;

  localparam logic [23:0] DATA_OFFSET_RST   = 24'd6144;
  localparam logic [15:0] CLUSTER_BYTES_RST = 16'd1024;
  localparam logic [11:0] CLUSTER_LIMIT_RST = 12'd354;
  localparam logic [23:0] IMAGE_BYTES_RST   = 24'd368640;

  localparam logic [11:0] END_MARK = 12'hFF8;

  typedef enum logic [2:0] {
    ST_ACK    = 3'd0,
    ST_GIVEN  = 3'd1,
    ST_END    = 3'd2,
    ST_HOPS   = 3'd3,
    ST_BEYOND = 3'd4,
    ST_IDLE   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_START,
    S_NONE,
    S_ADV1,
    S_ADV2,
    S_ADV3
  } state_t;

  typedef enum logic [1:0] {
    RK_LOAD,
    RK_START,
    RK_NONE,
    RK_ADV
  } res_kind_t;

  typedef struct packed {
    logic      latch;
    logic      adv1;
    logic      adv2;
    logic      emit;
    res_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fat12cw_ctrl.sv =====
// Controller state machine that sequences each word through the datapath.
`default_nettype none

module fat12cw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [1:0]          op,
  input  fat12cw_pkg::sts_t   sts,
  output fat12cw_pkg::cmd_t   cmd
);

  fat12cw_pkg::state_t state;
  fat12cw_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fat12cw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.kind   = fat12cw_pkg::RK_NONE;
    item_stall = 1'b1;
    case (state)
      fat12cw_pkg::S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.latch = 1'b1;
          case (op)
            fat12cw_pkg::OP_LOAD:  state_next = fat12cw_pkg::S_LOAD;
            fat12cw_pkg::OP_START: state_next = fat12cw_pkg::S_START;
            fat12cw_pkg::OP_ADV: begin
              state_next = sts.active ? fat12cw_pkg::S_ADV1 : fat12cw_pkg::S_NONE;
            end
            default:               state_next = fat12cw_pkg::S_NONE;
          endcase
        end
      end
      fat12cw_pkg::S_LOAD: begin
        cmd.kind = fat12cw_pkg::RK_LOAD;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = fat12cw_pkg::S_IDLE;
        end
      end
      fat12cw_pkg::S_START: begin
        cmd.kind = fat12cw_pkg::RK_START;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = fat12cw_pkg::S_IDLE;
        end
      end
      fat12cw_pkg::S_NONE: begin
        cmd.kind = fat12cw_pkg::RK_NONE;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = fat12cw_pkg::S_IDLE;
        end
      end
      fat12cw_pkg::S_ADV1: begin
        cmd.adv1   = 1'b1;
        state_next = fat12cw_pkg::S_ADV2;
      end
      fat12cw_pkg::S_ADV2: begin
        cmd.adv2   = 1'b1;
        state_next = fat12cw_pkg::S_ADV3;
      end
      fat12cw_pkg::S_ADV3: begin
        cmd.kind = fat12cw_pkg::RK_ADV;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = fat12cw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fat12cw_pkg::S_IDLE;
      end
    endcase
  end

  // A word is taken only once before its result is produced.
  a_latch_once: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> !cmd.latch)
    else $error("second word taken while one is in flight");

  // A result is never produced over one that still waits.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result produced while output register is full");

endmodule

`default_nettype wire

// ===== hw/rtl/fat12cw_dp.sv =====
// Datapath with table store, chain registers, configuration and output register.
`default_nettype none

module fat12cw_dp #(
  parameter int FAT_BYTES = fat12cw_pkg::FAT_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  fat12cw_pkg::cmd_t   cmd,
  output fat12cw_pkg::sts_t   sts,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic [12:0]         fat_index,
  input  logic [7:0]          fat_byte,
  input  logic [11:0]         start_cluster,
  input  logic [31:0]         size_limit,
  input  logic                cap_enable,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [2:0]          status,
  output logic [11:0]         cluster,
  output logic [23:0]         byte_offset,
  output logic [15:0]         byte_count,
  output logic                done_res
);

  localparam int AW = $clog2(FAT_BYTES);

  logic [7:0]  mem [FAT_BYTES];
  logic [7:0]  rdata;

  logic [23:0] data_offset;
  logic [15:0] cluster_bytes;
  logic [11:0] cluster_limit;
  logic [23:0] image_bytes;

  logic [12:0] idx_q;
  logic [7:0]  byte_q;
  logic [11:0] start_q;
  logic [31:0] size_q;
  logic        cap_q;

  logic [11:0] current_cluster;
  logic [12:0] hop_count;
  logic [31:0] bytes_passed;
  logic [31:0] size_cap;
  logic        cap_on;
  logic        chain_active;

  logic [27:0] prod;
  logic [28:0] off;
  logic [15:0] cnt;
  logic [7:0]  lo_byte;
  logic        pos_ok;
  logic        pos1_ok;

  fat12cw_pkg::status_t status_q;

  logic [13:0] triple;
  logic [12:0] pos;
  logic [13:0] pos1;
  logic        idx_ok;
  logic        mem_we;
  logic [11:0] cm2;
  logic [31:0] left;
  logic [15:0] cnt_c;
  logic [32:0] bp_sum;
  logic [31:0] bp_sat;
  logic [29:0] off_end;
  logic        is_end;
  logic        is_hops;
  logic        is_beyond;
  logic [7:0]  hi_byte;
  logic [15:0] word;
  logic [11:0] entry;
  logic        emit_adv;

  assign triple   = {2'b00, current_cluster} + {1'b0, current_cluster, 1'b0};
  assign pos      = triple[13:1];
  assign pos1     = {1'b0, pos} + 14'd1;
  assign idx_ok   = 32'(idx_q) < 32'(FAT_BYTES);
  assign mem_we   = cmd.emit && (cmd.kind == fat12cw_pkg::RK_LOAD) && idx_ok;
  assign cm2      = current_cluster - 12'd2;
  assign left     = (size_cap > bytes_passed) ? (size_cap - bytes_passed) : 32'd0;
  assign cnt_c    = (cap_on && (left < 32'(cluster_bytes))) ? left[15:0] : cluster_bytes;
  assign bp_sum   = {1'b0, bytes_passed} + 33'(cluster_bytes);
  assign bp_sat   = bp_sum[32] ? 32'hFFFF_FFFF : bp_sum[31:0];
  assign off_end  = {1'b0, off} + 30'(cluster_bytes);
  assign is_end   = (current_cluster < 12'd2) || (current_cluster >= fat12cw_pkg::END_MARK);
  assign is_hops  = hop_count > {1'b0, cluster_limit};
  assign is_beyond = off_end > 30'(image_bytes);
  assign hi_byte  = pos1_ok ? rdata : 8'd0;
  assign word     = {hi_byte, lo_byte};
  assign entry    = current_cluster[0] ? word[15:4] : word[11:0];
  assign emit_adv = cmd.emit && (cmd.kind == fat12cw_pkg::RK_ADV);

  assign sts.active   = chain_active;
  assign sts.out_free = !res_valid || !res_stall;
  assign status       = status_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(idx_q)] <= byte_q;
    end
    if (cmd.adv1) begin
      rdata <= mem[AW'(pos)];
    end else if (cmd.adv2) begin
      rdata <= mem[AW'(pos1)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      idx_q   <= fat_index;
      byte_q  <= fat_byte;
      start_q <= start_cluster;
      size_q  <= size_limit;
      cap_q   <= cap_enable;
    end
    if (cmd.adv1) begin
      prod    <= {16'd0, cm2} * {12'd0, cluster_bytes};
      pos_ok  <= 32'(pos) < 32'(FAT_BYTES);
      pos1_ok <= 32'(pos1) < 32'(FAT_BYTES);
      cnt     <= cnt_c;
    end
    if (cmd.adv2) begin
      off     <= 29'(data_offset) + 29'(prod);
      lo_byte <= pos_ok ? rdata : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_offset     <= fat12cw_pkg::DATA_OFFSET_RST;
      cluster_bytes   <= fat12cw_pkg::CLUSTER_BYTES_RST;
      cluster_limit   <= fat12cw_pkg::CLUSTER_LIMIT_RST;
      image_bytes     <= fat12cw_pkg::IMAGE_BYTES_RST;
      current_cluster <= '0;
      hop_count       <= '0;
      bytes_passed    <= '0;
      size_cap        <= '0;
      cap_on          <= 1'b0;
      chain_active    <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fat12cw_pkg::CFG_DATA_OFFSET:   data_offset   <= cfg_data;
          fat12cw_pkg::CFG_CLUSTER_BYTES: cluster_bytes <= cfg_data[15:0];
          fat12cw_pkg::CFG_CLUSTER_LIMIT: cluster_limit <= cfg_data[11:0];
          fat12cw_pkg::CFG_IMAGE_BYTES:   image_bytes   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (cmd.emit && (cmd.kind == fat12cw_pkg::RK_START)) begin
        current_cluster <= start_q;
        size_cap        <= size_q;
        cap_on          <= cap_q;
        hop_count       <= '0;
        bytes_passed    <= '0;
        chain_active    <= 1'b1;
      end
      if (emit_adv) begin
        if (is_end || is_hops) begin
          chain_active <= 1'b0;
        end else begin
          hop_count <= hop_count + 13'd1;
          if (is_beyond) begin
            chain_active <= 1'b0;
          end else begin
            bytes_passed    <= bp_sat;
            current_cluster <= entry;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status_q    <= fat12cw_pkg::ST_IDLE;
      cluster     <= '0;
      byte_offset <= '0;
      byte_count  <= '0;
      done_res    <= 1'b0;
      case (cmd.kind)
        fat12cw_pkg::RK_LOAD: begin
          status_q <= fat12cw_pkg::ST_ACK;
        end
        fat12cw_pkg::RK_START: begin
          status_q <= fat12cw_pkg::ST_ACK;
          cluster  <= start_q;
        end
        fat12cw_pkg::RK_ADV: begin
          cluster <= current_cluster;
          if (is_end) begin
            status_q <= fat12cw_pkg::ST_END;
            done_res <= 1'b1;
          end else if (is_hops) begin
            status_q <= fat12cw_pkg::ST_HOPS;
            done_res <= 1'b1;
          end else if (is_beyond) begin
            status_q <= fat12cw_pkg::ST_BEYOND;
            done_res <= 1'b1;
          end else begin
            status_q    <= fat12cw_pkg::ST_GIVEN;
            byte_offset <= off[23:0];
            byte_count  <= cnt;
          end
        end
        default: begin
          status_q <= fat12cw_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // A produced result is offered on the next cycle.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> res_valid)
    else $error("produced result not offered");

  // A chain stops only through an advance result.
  a_chain_stop: assert property (@(posedge clk) disable iff (rst)
    ($fell(chain_active) && !$past(rst)) |->
      $past(cmd.emit && (cmd.kind == fat12cw_pkg::RK_ADV)))
    else $error("chain stopped without an advance result");

  // A trimmed count never exceeds one cluster.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (status_q == fat12cw_pkg::ST_GIVEN)) |-> (byte_count <= cluster_bytes))
    else $error("byte count larger than a cluster");

endmodule

`default_nettype wire

// ===== hw/rtl/fat12_cluster_chain_walker.sv =====
// Top level of the FAT12 cluster chain walker.
`default_nettype none

// Walks a FAT12 cluster chain held in an internal byte store of FAT_BYTES bytes.
// A load word writes one table byte, a start word sets the first cluster and size
// cap, and each advance word reports one cluster (offset and kept byte count) or
// why the chain stopped. Load, start and rejected words go from acceptance to
// their result state; an advance goes through S_ADV1, S_ADV2 and S_ADV3, set by
// the single-port table store, read once for each of the two entry bytes, and
// by the registered offset multiply. A new word is taken while the previous
// result waits on the output register. The table store is not cleared at reset;
// entries must be loaded before the chain reads them.
module fat12_cluster_chain_walker #(
  parameter int FAT_BYTES = fat12cw_pkg::FAT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  op,
  input  logic [12:0] fat_index,
  input  logic [7:0]  fat_byte,
  input  logic [11:0] start_cluster,
  input  logic [31:0] size_limit,
  input  logic        cap_enable,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  status,
  output logic [11:0] cluster,
  output logic [23:0] byte_offset,
  output logic [15:0] byte_count,
  output logic        done_res
);

  fat12cw_pkg::cmd_t cmd;
  fat12cw_pkg::sts_t sts;

  fat12cw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .op         (op),
    .sts        (sts),
    .cmd        (cmd)
  );

  fat12cw_dp #(
    .FAT_BYTES (FAT_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fat_index     (fat_index),
    .fat_byte      (fat_byte),
    .start_cluster (start_cluster),
    .size_limit    (size_limit),
    .cap_enable    (cap_enable),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .status        (status),
    .cluster       (cluster),
    .byte_offset   (byte_offset),
    .byte_count    (byte_count),
    .done_res      (done_res)
  );

endmodule

`default_nettype wire

// ===== sim/fat12_cluster_chain_walker_test.sv =====
// Self-checking testbench of the FAT12 cluster chain walker with random table chains.
module fat12_cluster_chain_walker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fat12cw_pkg::*;

  localparam int TABLE_BYTES = FAT_BYTES_DEF;
  localparam int LAST_DATA = int'(END_MARK) - 1;
  localparam int NO_PROGRESS_LIMIT = 3000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [12:0] fat_index;
    logic [7:0]  fat_byte;
    logic [11:0] start_cluster;
    logic [31:0] size_limit;
    logic        cap_enable;
  } word_t;

  typedef struct {
    logic [2:0]  status;
    logic [11:0] cluster;
    logic [23:0] byte_offset;
    logic [15:0] byte_count;
    logic        done_res;
  } report_t;

  class walk_scoreboard;
    logic [7:0]  fat_copy [TABLE_BYTES];
    bit          written [TABLE_BYTES];
    logic [11:0] cur;
    logic [12:0] hops;
    logic [31:0] passed;
    logic [31:0] cap;
    bit          cap_on;
    bit          active;
    logic [23:0] base_off;
    logic [15:0] clus_bytes;
    logic [11:0] clus_limit;
    logic [23:0] image_size;
    report_t     due[$];
    int          failures;
    int          tally [8];

    function new();
      cur = '0;
      hops = '0;
      passed = '0;
      cap = '0;
      cap_on = 0;
      active = 0;
      base_off = DATA_OFFSET_RST;
      clus_bytes = CLUSTER_BYTES_RST;
      clus_limit = CLUSTER_LIMIT_RST;
      image_size = IMAGE_BYTES_RST;
      failures = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        CFG_DATA_OFFSET:   base_off = val;
        CFG_CLUSTER_BYTES: clus_bytes = val[15:0];
        CFG_CLUSTER_LIMIT: clus_limit = val[11:0];
        CFG_IMAGE_BYTES:   image_size = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] table_at(int pos);
      return (pos < TABLE_BYTES) ? fat_copy[pos] : 8'h00;
    endfunction

    function logic [11:0] entry_of(logic [11:0] n);
      int pos;
      logic [15:0] pair;
      pos = (int'(n) * 3) / 2;
      pair = {table_at(pos + 1), table_at(pos)};
      return n[0] ? pair[15:4] : pair[11:0];
    endfunction

    function longint cluster_offset(logic [11:0] c);
      return longint'(base_off) + (longint'(c) - 2) * longint'(clus_bytes);
    endfunction

    // True when the next advance gives a cluster and so reads its table entry.
    function bit reads_entry(output int pos);
      pos = (int'(cur) * 3) / 2;
      return active && cur >= 2 && cur < END_MARK && hops <= clus_limit &&
             cluster_offset(cur) + longint'(clus_bytes) <= longint'(image_size);
    endfunction

    function void note_word(word_t w);
      report_t r;
      longint off;
      longint sum;
      logic [31:0] left;
      logic [31:0] cnt;
      r = '{ST_IDLE, 12'd0, 24'd0, 16'd0, 1'b0};
      case (w.op)
        OP_LOAD: begin
          if (w.fat_index < TABLE_BYTES) begin
            fat_copy[w.fat_index] = w.fat_byte;
            written[w.fat_index] = 1;
          end
          r.status = ST_ACK;
        end
        OP_START: begin
          cur = w.start_cluster;
          cap = w.size_limit;
          cap_on = w.cap_enable;
          hops = '0;
          passed = '0;
          active = 1;
          r.status = ST_ACK;
          r.cluster = w.start_cluster;
        end
        OP_ADV: begin
          if (active) begin
            r.cluster = cur;
            if (cur < 2 || cur >= END_MARK) begin
              active = 0;
              r.status = ST_END;
              r.done_res = 1;
            end else if (hops > clus_limit) begin
              active = 0;
              r.status = ST_HOPS;
              r.done_res = 1;
            end else begin
              hops = hops + 13'd1;
              off = cluster_offset(cur);
              if (off + longint'(clus_bytes) > longint'(image_size)) begin
                active = 0;
                r.status = ST_BEYOND;
                r.done_res = 1;
              end else begin
                cnt = 32'(clus_bytes);
                if (cap_on) begin
                  left = (cap > passed) ? cap - passed : 32'd0;
                  if (left < cnt) cnt = left;
                end
                sum = longint'(passed) + longint'(clus_bytes);
                passed = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                r.status = ST_GIVEN;
                r.byte_offset = off[23:0];
                r.byte_count = cnt[15:0];
                cur = entry_of(cur);
              end
            end
          end
        end
        default: ;
      endcase
      due.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (due.size() == 0) begin
        $error("result word with nothing expected: status %0d cluster %0d",
               got.status, got.cluster);
        failures++;
        return;
      end
      want = due.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("cluster", 32'(want.cluster), 32'(got.cluster));
      compare_field("byte_offset", 32'(want.byte_offset), 32'(got.byte_offset));
      compare_field("byte_count", 32'(want.byte_count), 32'(got.byte_count));
      compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
      tally[want.status]++;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        item_valid;
  logic        item_stall;
  logic [1:0]  op;
  logic [12:0] fat_index;
  logic [7:0]  fat_byte;
  logic [11:0] start_cluster;
  logic [31:0] size_limit;
  logic        cap_enable;
  logic        res_valid;
  logic        res_stall;
  logic [2:0]  status;
  logic [11:0] cluster;
  logic [23:0] byte_offset;
  logic [15:0] byte_count;
  logic        done_res;

  walk_scoreboard sb;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int words_sent = 0;
  int settings_used = 0;
  int quiet_count = 0;

  fat12_cluster_chain_walker dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .op(op),
    .fat_index(fat_index),
    .fat_byte(fat_byte),
    .start_cluster(start_cluster),
    .size_limit(size_limit),
    .cap_enable(cap_enable),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .status(status),
    .cluster(cluster),
    .byte_offset(byte_offset),
    .byte_count(byte_count),
    .done_res(done_res)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // The receiver holds off for a counted stretch when asked, else stalls at random.
  initial begin
    res_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_stall = 1;
        hold_left--;
      end else begin
        res_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      sb.check_report('{status, cluster, byte_offset, byte_count, done_res});
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (res_valid && !res_stall)) begin
      quiet_count = 0;
    end else begin
      quiet_count++;
    end
    if (quiet_count >= NO_PROGRESS_LIMIT) begin
      $display("No word moved for %0d cycles.", NO_PROGRESS_LIMIT);
      $display("** fat12_cluster_chain_walker: FAILED **");
      $finish;
    end
  end

  function automatic word_t noise_word();
    word_t w;
    w.op = 2'($urandom_range(3));
    w.fat_index = 13'($urandom_range(TABLE_BYTES - 1));
    w.fat_byte = 8'($urandom);
    w.start_cluster = 12'($urandom);
    w.size_limit = $urandom;
    w.cap_enable = 1'($urandom);
    return w;
  endfunction

  task automatic send_word(word_t w);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      item_valid = 0;
      @(negedge clk);
    end
    op = w.op;
    fat_index = w.fat_index;
    fat_byte = w.fat_byte;
    start_cluster = w.start_cluster;
    size_limit = w.size_limit;
    cap_enable = w.cap_enable;
    item_valid = 1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic put_load(int idx, logic [7:0] value);
    word_t w;
    w = noise_word();
    w.op = OP_LOAD;
    w.fat_index = 13'(idx);
    w.fat_byte = value;
    send_word(w);
  endtask

  task automatic put_start(logic [11:0] c, logic [31:0] size, logic capped);
    word_t w;
    w = noise_word();
    w.op = OP_START;
    w.start_cluster = c;
    w.size_limit = size;
    w.cap_enable = capped;
    send_word(w);
  endtask

  // Table bytes that the advance will read are loaded first if still unwritten.
  task automatic put_adv();
    word_t w;
    int pos;
    if (sb.reads_entry(pos)) begin
      if (!sb.written[pos]) put_load(pos, 8'($urandom));
      if (!sb.written[pos + 1]) put_load(pos + 1, 8'($urandom));
    end
    w = noise_word();
    w.op = OP_ADV;
    send_word(w);
  endtask

  task automatic put_unused_op();
    word_t w;
    w = noise_word();
    w.op = OP_UNUSED;
    send_word(w);
  endtask

  task automatic set_entry(logic [11:0] n, logic [11:0] value);
    int pos;
    logic [7:0] lo;
    logic [7:0] hi;
    pos = (int'(n) * 3) / 2;
    lo = sb.written[pos] ? sb.fat_copy[pos] : 8'($urandom);
    hi = sb.written[pos + 1] ? sb.fat_copy[pos + 1] : 8'($urandom);
    if (n[0]) begin
      lo = {value[3:0], lo[3:0]};
      hi = value[11:4];
    end else begin
      lo = value[7:0];
      hi = {hi[7:4], value[11:8]};
    end
    put_load(pos, lo);
    put_load(pos + 1, hi);
  endtask

  task automatic settle();
    @(negedge clk);
    item_valid = 0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] value);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 0;
    sb.set_reg(idx, value);
  endtask

  task automatic set_regs(logic [23:0] off, logic [23:0] bytes, logic [23:0] lim,
                          logic [23:0] img);
    settle();
    write_reg(CFG_DATA_OFFSET, off);
    write_reg(CFG_CLUSTER_BYTES, bytes);
    write_reg(CFG_CLUSTER_LIMIT, lim);
    write_reg(CFG_IMAGE_BYTES, img);
    settings_used++;
  endtask

  task automatic set_idling(int mode, bit quiet);
    gap_pct = 0;
    stall_pct = 0;
    if (!quiet) begin
      case (mode)
        1: gap_pct = 77;
        2: stall_pct = 77;
        3: begin
          gap_pct = 16;
          stall_pct = 16;
        end
        default: ;
      endcase
    end
  endtask

  // Builds a linked chain in the table, starts it and advances it past its last link.
  task automatic walk_chain();
    int len;
    int hi;
    int n_adv;
    longint room;
    logic [11:0] links [8];
    logic [11:0] tail;
    room = longint'(sb.image_size) - longint'(sb.base_off) - longint'(sb.clus_bytes);
    if (sb.clus_bytes == 0) hi = LAST_DATA;
    else if (room < 0) hi = 1;
    else hi = (room / sb.clus_bytes + 2 > LAST_DATA) ? LAST_DATA : int'(room / sb.clus_bytes) + 2;
    if (hi < 2) hi = LAST_DATA;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) links[i] = 12'($urandom_range(2, hi));
    case ($urandom_range(4))
      0: tail = END_MARK + 12'($urandom_range(7));
      1: tail = 12'($urandom_range(1));
      2: tail = links[$urandom_range(len - 1)];
      3: tail = (hi < LAST_DATA) ? 12'($urandom_range(hi + 1, LAST_DATA))
                                 : 12'($urandom_range(int'(END_MARK), 4095));
      default: tail = 12'($urandom);
    endcase
    for (int i = 0; i < len - 1; i++) set_entry(links[i], links[i + 1]);
    set_entry(links[len - 1], tail);
    put_start(links[0], $urandom_range(1) ? $urandom_range(0, len * int'(sb.clus_bytes))
                                          : $urandom, 1'($urandom));
    n_adv = len + 1 + $urandom_range(4);
    for (int i = 0; i < n_adv; i++) put_adv();
  endtask

  task automatic random_phase(int budget, int mode);
    int first;
    int pick;
    first = words_sent;
    while (words_sent - first < budget) begin
      set_idling(mode, $urandom_range(4) == 0);
      pick = $urandom_range(99);
      if (pick < 70) walk_chain();
      else if (pick < 82) put_load($urandom_range(TABLE_BYTES - 1), 8'($urandom));
      else if (pick < 90) put_start(12'($urandom), $urandom, 1'($urandom));
      else if (pick < 97) put_adv();
      else put_unused_op();
    end
  endtask

  initial begin
    logic [23:0] r_off;
    logic [23:0] r_bytes;
    sb = new();
    rst = 1;
    cfg_we = 0;
    cfg_index = CFG_DATA_OFFSET;
    cfg_data = '0;
    item_valid = 0;
    op = OP_LOAD;
    fat_index = '0;
    fat_byte = '0;
    start_cluster = '0;
    size_limit = '0;
    cap_enable = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed words, first under the reset settings.
    put_adv();
    put_unused_op();
    set_entry(12'd2, 12'd3);
    set_entry(12'd3, 12'hFFF);
    put_start(12'd2, 32'd1500, 1'b1);
    repeat (4) put_adv();
    put_start(12'd0, 32'hFFFF_FFFF, 1'b1);
    put_adv();
    put_start(12'd1, 32'd0, 1'b0);
    put_adv();
    put_start(END_MARK, 32'd0, 1'b0);
    put_adv();
    put_start(12'd356, 32'd0, 1'b1);
    put_adv();
    set_entry(12'd355, END_MARK);
    put_start(12'd355, 32'd0, 1'b1);
    repeat (2) put_adv();
    set_regs(24'd6144, 24'd1024, 24'd1, 24'd368640);
    set_entry(12'd4, 12'd4);
    put_start(12'd4, 32'hFFFF_FFFF, 1'b0);
    repeat (3) put_adv();

    set_regs(24'd0, 24'd1, 24'd0, 24'hFF_FFFF);
    random_phase(40, 0);
    hold_left = 90;
    random_phase(100, 0);
    set_regs(24'd512, 24'd512, 24'd4095, 24'hFF_FFFF);
    random_phase(170, 1);
    set_regs(24'hFF_FFFF, 24'd32768, 24'd4095, 24'hFF_FFFF);
    random_phase(50, 2);
    set_regs(24'd0, 24'd32768, 24'd12, 24'hFF_FFFF);
    random_phase(80, 3);
    settle();
    random_phase(80, 3);
    r_off = 24'($urandom_range(0, 200000));
    r_bytes = 24'($urandom_range(1, 4096));
    set_regs(r_off, r_bytes, 24'($urandom_range(2, 30)),
             r_off + r_bytes * 24'($urandom_range(40, 600)));
    random_phase(170, 2);
    set_regs(24'd0, 24'd0, 24'd8, 24'd0);
    random_phase(70, 3);
    set_regs(DATA_OFFSET_RST, 24'(CLUSTER_BYTES_RST), 24'(CLUSTER_LIMIT_RST), IMAGE_BYTES_RST);
    random_phase(80, 1);
    set_idling(0, 1);
    settle();

    $display("Run covered %0d words over %0d register settings.", words_sent, settings_used + 1);
    $display("Results: %0d clusters, %0d end marks, %0d hop limits, %0d beyond image, %0d idle.",
             sb.tally[ST_GIVEN], sb.tally[ST_END], sb.tally[ST_HOPS], sb.tally[ST_BEYOND],
             sb.tally[ST_IDLE]);
    if (sb.failures == 0 && sb.due.size() == 0) begin
      $display("** fat12_cluster_chain_walker: PASSED **");
    end else begin
      $display("** fat12_cluster_chain_walker: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fat12cw_pkg.sv
hw/rtl/fat12cw_ctrl.sv
hw/rtl/fat12cw_dp.sv
hw/rtl/fat12_cluster_chain_walker.sv
sim/fat12_cluster_chain_walker_test.sv
